@@ src/smsd_pkg.sv @@
//------------------------------------------------------------------------------
// Sample mean and deviation package
// Shared constants and the sequencer state type.
//------------------------------------------------------------------------------
`default_nettype none

package smsd_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = 11;

   localparam logic [1:0] CSR_SKIP_COUNT     = 2'd0;
   localparam logic [1:0] CSR_USE_GIVEN_MEAN = 2'd1;
   localparam logic [1:0] CSR_GIVEN_MEAN     = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_SINGLE   = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic [31:0] MINUS_ONE_Q16 = 32'hFFFF_0000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MEAN_DIV,
      S_MEAN_FIX,
      S_RD,
      S_SQ,
      S_ACC,
      S_VAR_DIV,
      S_SQRT,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

@@ src/sample_mean_std_dev.sv @@
//------------------------------------------------------------------------------
// Sample mean and sample standard deviation
// Loads Q16.16 samples into a store and reports mean and deviation on last.
//------------------------------------------------------------------------------
// A beat is taken on req_ at a rising edge with start high and busy low.
// A beat without last stores and sums its sample, unless it is skipped or
// the store is full. On a beat with last the block goes busy and computes
// with one shared serial unit: a 48-bit restoring division for the mean,
// one pass over the store (read, square and accumulate), a 64-bit
// restoring division by the count minus one and a 32-step square root.
// The deviation saturates to all ones when the variance overflows; an
// empty list skips all of this and a single sample skips all but the mean.
// The result appears on rsp_ in the cycle that busy falls, for exactly one
// cycle with rsp_valid high; the receiver cannot stall, and a new beat may
// already be taken in that cycle.
// Configuration writes go through csr_ at any time the block is idle.
// Synchronous reset clears configuration, control and list state; the store
// is not cleared since only entries written in the current list are read.
//------------------------------------------------------------------------------
`default_nettype none

module sample_mean_std_dev
   import smsd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_sample,
   input  wire logic               req_last,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_mean,
   output logic [31:0]             rsp_std_dev,
   output logic [CNT_W-1:0]        rsp_sample_count,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  skip_ff;
   logic              use_given_ff;
   logic signed [31:0] given_ff;

   logic [31:0] store [MAX_SAMPLES];
   logic [31:0] rd_data_ff;

   logic [CNT_W-1:0] stored_ff, seen_ff;
   logic signed [47:0] sum_ff;
   logic ovf_ff;

   logic [63:0] quot_ff, quot_in;
   logic [64:0] rem_ff, rem_in;
   logic [6:0]  step_ff, step_in;
   logic [47:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic signed [31:0] mean_ff, mean_in;
   logic signed [32:0] center_ff, center_in;
   logic [ADDR_W:0] idx_ff, idx_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] lo_ff, lo_in;
   logic [10:0] hi_ff, hi_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] sd_ff, sd_in;
   logic        valid_in;
   logic [1:0]  status_in;

   logic accept, do_store;
   logic [CNT_W-1:0] n_now;
   logic [64:0] trial;
   logic [33:0] sq_trial;
   logic signed [32:0] dev;
   logic [32:0] dev_mag;
   logic [64:0] lo_sum;
   logic [CNT_W-1:0] dm1;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign do_store = accept && (seen_ff >= skip_ff) && (stored_ff < CNT_W'(MAX_SAMPLES));
   assign dm1 = stored_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= '0;
         use_given_ff <= 1'b0;
         given_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SKIP_COUNT:     skip_ff <= csr_wdata[CNT_W-1:0];
            CSR_USE_GIVEN_MEAN: use_given_ff <= csr_wdata[0];
            CSR_GIVEN_MEAN:     given_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         store[stored_ff[ADDR_W-1:0]] <= req_sample;
      end
      rd_data_ff <= store[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         seen_ff <= '0;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (valid_in) begin
         stored_ff <= '0;
         seen_ff <= '0;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (accept) begin
         if (seen_ff < skip_ff) begin
            if (seen_ff != '1) seen_ff <= seen_ff + CNT_W'(1);
         end else if (stored_ff < CNT_W'(MAX_SAMPLES)) begin
            stored_ff <= stored_ff + CNT_W'(1);
            sum_ff <= sum_ff + 48'(req_sample);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   assign n_now = stored_ff;

   always_comb begin
      state_in  = state_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      mean_in   = mean_ff;
      center_in = center_ff;
      idx_in    = idx_ff;
      sq_in     = sq_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      root_in   = root_ff;
      sd_in     = sd_ff;
      valid_in  = 1'b0;
      status_in = ST_OK;
      trial     = '0;
      sq_trial  = '0;
      dev       = '0;
      dev_mag   = '0;
      lo_sum    = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_last) begin
               state_in = S_MEAN_DIV;
            end
         end
         S_MEAN_DIV: begin
            // Entered once the last beat has been taken, so counts are final.
            if (step_ff == 7'd0) begin
               if (n_now == '0) begin
                  mean_in = MINUS_ONE_Q16;
                  sd_in = '0;
                  state_in = S_DONE;
               end else begin
                  neg_in = sum_ff[47];
                  mag_in = sum_ff[47] ? 48'(-sum_ff) : 48'(sum_ff);
                  rem_in = '0;
                  quot_in = '0;
                  step_in = 7'd48;
               end
            end else begin
               trial = {rem_ff[63:0], mag_ff[47]} - 65'(n_now);
               mag_in = {mag_ff[46:0], 1'b0};
               if (!trial[64]) begin
                  rem_in = trial;
                  quot_in = {quot_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[63:0], mag_ff[47]};
                  quot_in = {quot_ff[62:0], 1'b0};
               end
               step_in = step_ff - 7'd1;
               if (step_ff == 7'd1) state_in = S_MEAN_FIX;
            end
         end
         S_MEAN_FIX: begin
            if (neg_ff) begin
               mean_in = 32'(-(quot_ff[47:0] + 48'(rem_ff != '0)));
            end else begin
               mean_in = quot_ff[31:0];
            end
            idx_in = '0;
            lo_in = '0;
            hi_in = '0;
            sd_in = '0;
            state_in = (n_now == CNT_W'(1)) ? S_DONE : S_RD;
         end
         S_RD: begin
            center_in = use_given_ff ? 33'(given_ff) : 33'(mean_ff);
            state_in = S_SQ;
         end
         S_SQ: begin
            dev = 33'(signed'(rd_data_ff)) - center_ff;
            dev_mag = dev[32] ? 33'(-dev) : 33'(dev);
            sq_in = 64'(dev_mag) * 64'(dev_mag);
            idx_in = idx_ff + (ADDR_W+1)'(1);
            state_in = S_ACC;
         end
         S_ACC: begin
            lo_sum = 65'(lo_ff) + 65'(sq_ff);
            lo_in = lo_sum[63:0];
            hi_in = hi_ff + 11'(lo_sum[64]);
            if (idx_ff == (ADDR_W+1)'(n_now)) begin
               state_in = S_VAR_DIV;
               rem_in = 65'(hi_ff + 11'(lo_sum[64]));
               quot_in = '0;
               mag_in = '0;
               step_in = 7'd64;
            end else begin
               state_in = S_SQ;
            end
         end
         S_VAR_DIV: begin
            if (step_ff == 7'd64 && rem_ff >= 65'(dm1)) begin
               sd_in = '1;
               state_in = S_DONE;
            end else begin
               trial = {rem_ff[63:0], lo_ff[63]} - 65'(dm1);
               lo_in = {lo_ff[62:0], 1'b0};
               if (!trial[64]) begin
                  rem_in = trial;
                  quot_in = {quot_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[63:0], lo_ff[63]};
                  quot_in = {quot_ff[62:0], 1'b0};
               end
               step_in = step_ff - 7'd1;
               if (step_ff == 7'd1) begin
                  state_in = S_SQRT;
                  step_in = 7'd32;
                  rem_in = '0;
                  root_in = '0;
               end
            end
         end
         S_SQRT: begin
            // Digit-by-digit root: two radicand bits per step.
            sq_trial = {rem_ff[31:0], quot_ff[63:62]} - {root_ff, 2'b01};
            if (!sq_trial[33]) begin
               rem_in = 65'(sq_trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in = 65'({rem_ff[31:0], quot_ff[63:62]});
               root_in = {root_ff[30:0], 1'b0};
            end
            quot_in = {quot_ff[61:0], 2'b00};
            step_in = step_ff - 7'd1;
            if (step_ff == 7'd1) begin
               sd_in = root_in;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            valid_in = 1'b1;
            if (n_now == '0) status_in = ST_EMPTY;
            else if (n_now == CNT_W'(1)) status_in = ST_SINGLE;
            else status_in = ovf_ff ? ST_OVERFLOW : ST_OK;
            step_in = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      mean_ff <= mean_in;
      center_ff <= center_in;
      idx_ff <= idx_in;
      sq_ff <= sq_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      root_ff <= root_in;
      sd_ff <= sd_in;
      if (valid_in) begin
         rsp_mean <= mean_ff;
         rsp_std_dev <= sd_ff;
         rsp_sample_count <= n_now;
         rsp_status <= status_in;
      end
   end

   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy after result");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CNT_W'(MAX_SAMPLES)) else $error("store count out of range");
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> stored_ff == '0 || $past(accept)) else $error("list not cleared");

endmodule

`default_nettype wire

@@ tb/sv/tb_sample_mean_std_dev.sv @@
//------------------------------------------------------------------------------
// Testbench for the sample mean and standard deviation block
// Drives sample lists through the command port and checks every reported mean,
// deviation, count and status against a predictor held in a scoreboard class.
// Random gaps, register changes between phases, an overflowing list and empty
// lists are all covered.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sample_mean_std_dev;
   import smsd_pkg::*;

   typedef struct {
      logic [31:0]      mean;
      logic [31:0]      std_dev;
      logic [CNT_W-1:0] sample_count;
      logic [1:0]       status;
   } stats_type;

   class list_stats_scoreboard;
      int     skip_limit;
      bit     use_given;
      longint given_mean;
      longint kept_samples [MAX_SAMPLES];
      int     kept_count;
      int     skipped_count;
      longint kept_sum;
      bit     store_full;
      stats_type expected_stats [$];
      int     error_count;

      function new();
         skip_limit = 0;
         use_given = 0;
         given_mean = 0;
         error_count = 0;
         clear_list();
      endfunction

      function void clear_list();
         kept_count = 0;
         skipped_count = 0;
         kept_sum = 0;
         store_full = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            CSR_SKIP_COUNT: skip_limit = value[10:0];
            CSR_USE_GIVEN_MEAN: use_given = value[0];
            CSR_GIVEN_MEAN: given_mean = longint'($signed(value));
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [31:0] sample, bit last);
         longint      quot;
         longint      center;
         longint      diff;
         logic [63:0] mag;
         logic [127:0] sq_sum;
         logic [127:0] var_q;
         logic [63:0] rem;
         logic [63:0] root;
         logic [63:0] probe;
         stats_type   res;
         if (skipped_count < skip_limit) begin
            if (skipped_count < 2047) skipped_count++;
         end else if (kept_count < MAX_SAMPLES) begin
            kept_samples[kept_count] = longint'(sample);
            kept_count++;
            kept_sum += longint'(sample);
         end else begin
            store_full = 1;
         end
         if (!last) return;
         res.mean = MINUS_ONE_Q16;
         res.std_dev = 0;
         res.sample_count = kept_count[CNT_W-1:0];
         if (kept_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            quot = kept_sum / kept_count;
            if (kept_sum < 0 && quot * kept_count != kept_sum) quot--;
            res.mean = quot[31:0];
            if (kept_count == 1) begin
               res.status = ST_SINGLE;
            end else begin
               center = use_given ? given_mean : quot;
               sq_sum = 0;
               for (int i = 0; i < kept_count; i++) begin
                  diff = kept_samples[i] - center;
                  if (diff < 0) diff = -diff;
                  mag = diff;
                  sq_sum += 128'(mag) * 128'(mag);
               end
               var_q = sq_sum / 128'(kept_count - 1);
               if (var_q[127:64] != 0) begin
                  res.std_dev = 32'hFFFF_FFFF;
               end else begin
                  rem = var_q[63:0];
                  root = 0;
                  probe = 64'd1 << 62;
                  while (probe > rem) probe >>= 2;
                  while (probe != 0) begin
                     if (rem >= root + probe) begin
                        rem -= root + probe;
                        root = (root >> 1) + probe;
                     end else begin
                        root >>= 1;
                     end
                     probe >>= 2;
                  end
                  res.std_dev = root[31:0];
               end
               res.status = store_full ? ST_OVERFLOW : ST_OK;
            end
         end
         expected_stats.push_back(res);
         clear_list();
      endfunction

      function void check_result(logic [31:0] mean, logic [31:0] std_dev,
                                 logic [CNT_W-1:0] sample_count, logic [1:0] status);
         stats_type exp_s;
         if (expected_stats.size() == 0) begin
            $error("Unexpected result beat: mean %h std_dev %h", mean, std_dev);
            error_count++;
            return;
         end
         exp_s = expected_stats.pop_front();
         if (mean !== exp_s.mean) begin
            $error("mean: expected %h, actual %h", exp_s.mean, mean);
            error_count++;
         end
         if (std_dev !== exp_s.std_dev) begin
            $error("std_dev: expected %h, actual %h", exp_s.std_dev, std_dev);
            error_count++;
         end
         if (sample_count !== exp_s.sample_count) begin
            $error("sample_count: expected %0d, actual %0d", exp_s.sample_count,
                   sample_count);
            error_count++;
         end
         if (status !== exp_s.status) begin
            $error("status: expected %0d, actual %0d", exp_s.status, status);
            error_count++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 20000;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    start = 0;
   logic                    busy;
   logic signed [31:0]      req_sample = 0;
   logic                    req_last = 0;
   logic                    rsp_valid;
   logic signed [31:0]      rsp_mean;
   logic [31:0]             rsp_std_dev;
   logic [CNT_W-1:0]        rsp_sample_count;
   logic [1:0]              rsp_status;
   logic                    csr_write = 0;
   logic [1:0]              csr_index = CSR_SKIP_COUNT;
   logic [31:0]             csr_wdata = 0;

   list_stats_scoreboard stats_sb = new();
   int  beats_sent = 0;
   bit  quiet = 0;
   int  stall_cycles = 0;

   sample_mean_std_dev dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_mean(rsp_mean), .rsp_std_dev(rsp_std_dev),
      .rsp_sample_count(rsp_sample_count), .rsp_status(rsp_status),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         stats_sb.check_result(rsp_mean, rsp_std_dev, rsp_sample_count, rsp_status);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 0;
      stats_sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic send_beat(logic signed [31:0] sample, bit last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start <= 1;
      req_sample <= sample;
      req_last <= last;
      do @(posedge clock); while (busy);
      stats_sb.note_sample(sample, last);
      beats_sent++;
   endtask

   task automatic drain();
      start <= 0;
      while (stats_sb.expected_stats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample(logic [31:0] base);
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return base + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
         default: return base + $urandom_range(0, 255) - 128;
      endcase
   endfunction

   task automatic send_list(int len);
      logic [31:0] base;
      base = $urandom();
      for (int i = 0; i < len; i++) send_beat(pick_sample(base), i == len - 1);
   endtask

   initial begin
      int list_len;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Extremes, single sample, empty list and given mean.
      send_beat(32'sh7FFF_FFFF, 1);
      send_beat(32'sh8000_0000, 0);
      send_beat(32'sh7FFF_FFFF, 1);
      send_beat(32'sh8000_0000, 0);
      send_beat(32'sh8000_0000, 0);
      send_beat(-32'sd3, 1);
      send_beat(32'sd0, 0);
      send_beat(32'sd0, 1);
      drain();
      write_csr(CSR_SKIP_COUNT, 32'd2);
      send_beat(32'sd5, 0);
      send_beat(32'sd7, 1);
      send_beat(32'sd5, 0);
      send_beat(32'sd6, 0);
      send_beat(32'sd65536, 0);
      send_beat(-32'sd65536, 1);
      drain();
      write_csr(CSR_SKIP_COUNT, 32'd1024);
      send_beat(32'sd1, 0);
      send_beat(32'sd2, 1);
      drain();
      write_csr(CSR_SKIP_COUNT, 32'd0);
      write_csr(CSR_USE_GIVEN_MEAN, 32'd1);
      write_csr(CSR_GIVEN_MEAN, 32'h8000_0000);
      send_beat(32'sh7FFF_FFFF, 0);
      send_beat(32'sh7FFF_FFFF, 1);
      drain();
      write_csr(CSR_GIVEN_MEAN, 32'h7FFF_FFFF);
      send_beat(32'sh8000_0000, 0);
      send_beat(32'sh8000_0000, 0);
      send_beat(32'sd0, 1);
      drain();

      // A list that fills the store and then overflows it.
      write_csr(CSR_USE_GIVEN_MEAN, 32'd0);
      send_list(MAX_SAMPLES + 6);
      drain();

      while (beats_sent < 1650) begin
         if (beats_sent > 1450) quiet = 1;
         case ($urandom_range(0, 5))
            0: write_csr(CSR_SKIP_COUNT, $urandom_range(0, 1) ? 32'd1024 : 32'd0);
            1, 2: write_csr(CSR_SKIP_COUNT, $urandom_range(0, 6));
            default: ;
         endcase
         write_csr(CSR_USE_GIVEN_MEAN, $urandom_range(0, 1));
         write_csr(CSR_GIVEN_MEAN, $urandom());
         repeat ($urandom_range(2, 6)) begin
            list_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(2, 30);
            send_list(list_len);
         end
         drain();
      end

      drain();
      if (stats_sb.expected_stats.size() != 0) begin
         $error("%0d expected results never arrived", stats_sb.expected_stats.size());
         stats_sb.error_count++;
      end
      if (stats_sb.error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
